FILE: design/ssb_pkg.sv
package ssb_pkg;

    localparam int MAX_SCALE       = 8;
    localparam int MAX_IMAGE_WIDTH = 1024;

    localparam int PIX_W      = 32;
    localparam int ADDR_W     = 23;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int SCALE_W    = 4;
    localparam int IW_W       = 11;
    localparam int ORG_W      = 13;
    localparam int SCR_W      = 12;
    localparam int PITCH_W    = 13;
    localparam int POS_W      = 15;
    localparam int CRD_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLIP,
        S_SETUP,
        S_RUN
    } t_state;

    typedef struct packed {
        logic accept;
        logic clip;
        logic setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: design/ssb_ctrl.sv
module ssb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ssb_pkg::t_dp_sts i_sts,
    output ssb_pkg::t_dp_cmd o_cmd
);

    ssb_pkg::t_state r_state;
    ssb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ssb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ssb_pkg::S_CLIP;
                end
            end
            ssb_pkg::S_CLIP: begin
                // A square that lies wholly off screen produces nothing.
                o_cmd.clip = 1'b1;
                n_state    = i_sts.empty ? ssb_pkg::S_IDLE : ssb_pkg::S_SETUP;
            end
            ssb_pkg::S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ssb_pkg::S_RUN;
            end
            ssb_pkg::S_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = ssb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = ssb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ssb_datapath.sv
module ssb_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [ssb_pkg::PIX_W-1:0]          i_src_pixel,
    input  logic                               i_image_start,
    input  ssb_pkg::t_dp_cmd                   i_cmd,
    output ssb_pkg::t_dp_sts                   o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [ssb_pkg::ADDR_W-1:0]         o_word_address,
    output logic [ssb_pkg::PIX_W-1:0]          o_pixel_value,
    output logic                               o_last_of_square
);

    localparam int POS_W = ssb_pkg::POS_W;
    localparam int CRD_W = ssb_pkg::CRD_W;

    // Configuration registers.
    logic signed [ssb_pkg::ORG_W-1:0]   r_origin_x;
    logic signed [ssb_pkg::ORG_W-1:0]   r_origin_y;
    logic        [ssb_pkg::IW_W-1:0]    r_image_width;
    logic        [ssb_pkg::SCALE_W-1:0] r_scale_factor;
    logic        [ssb_pkg::SCR_W-1:0]   r_screen_width;
    logic        [ssb_pkg::SCR_W-1:0]   r_screen_height;
    logic        [ssb_pkg::PITCH_W-1:0] r_row_pitch;

    // Source position.
    logic [ssb_pkg::COL_W-1:0] r_col;
    logic [ssb_pkg::ROW_W-1:0] r_row;

    // Per-item working registers.
    logic        [ssb_pkg::PIX_W-1:0]  r_pixel;
    logic signed [POS_W-1:0]           r_base_x;
    logic signed [POS_W-1:0]           r_base_y;
    logic        [CRD_W-1:0]           r_x0;
    logic        [CRD_W-1:0]           r_x1;
    logic        [CRD_W-1:0]           r_y0;
    logic        [CRD_W-1:0]           r_y1;
    logic        [CRD_W-1:0]           r_x;
    logic        [CRD_W-1:0]           r_y;
    logic        [ssb_pkg::ADDR_W-1:0] r_row_base;

    // Output register.
    logic                       r_out_valid;
    logic [ssb_pkg::ADDR_W-1:0] r_out_addr;
    logic [ssb_pkg::PIX_W-1:0]  r_out_pixel;
    logic                       r_out_last;

    logic [ssb_pkg::SCALE_W-1:0] scale_eff;
    logic [ssb_pkg::IW_W-1:0]    width_eff;
    logic [ssb_pkg::COL_W-1:0]   col_cur;
    logic [ssb_pkg::ROW_W-1:0]   row_cur;
    logic [POS_W-2:0]            prod_x;
    logic [POS_W-2:0]            prod_y;
    logic signed [POS_W-1:0]     base_x;
    logic signed [POS_W-1:0]     base_y;
    logic signed [POS_W-1:0]     lo_x, hi_x, lo_y, hi_y;
    logic signed [POS_W-1:0]     end_x, end_y, lim_x, lim_y;
    logic                        empty;
    logic                        last;
    logic [ssb_pkg::ADDR_W-1:0]  cur_addr;
    logic [CRD_W+ssb_pkg::PITCH_W-1:0] row_prod;

    always_comb begin
        scale_eff = r_scale_factor;
        if (r_scale_factor == '0) begin
            scale_eff = ssb_pkg::SCALE_W'(1);
        end else if (r_scale_factor > ssb_pkg::SCALE_W'(ssb_pkg::MAX_SCALE)) begin
            scale_eff = ssb_pkg::SCALE_W'(ssb_pkg::MAX_SCALE);
        end
        width_eff = r_image_width;
        if (r_image_width == '0) begin
            width_eff = ssb_pkg::IW_W'(1);
        end else if (r_image_width > ssb_pkg::IW_W'(ssb_pkg::MAX_IMAGE_WIDTH)) begin
            width_eff = ssb_pkg::IW_W'(ssb_pkg::MAX_IMAGE_WIDTH);
        end
    end

    // Top-left corner of the square for the item being accepted.
    assign col_cur = i_image_start ? '0 : r_col;
    assign row_cur = i_image_start ? '0 : r_row;
    assign prod_x  = (POS_W-1)'(col_cur) * (POS_W-1)'(scale_eff);
    assign prod_y  = (POS_W-1)'(row_cur) * (POS_W-1)'(scale_eff);
    assign base_x  = POS_W'(r_origin_x) + $signed({1'b0, prod_x});
    assign base_y  = POS_W'(r_origin_y) + $signed({1'b0, prod_y});

    // Clip the square against the screen in each direction.
    always_comb begin
        end_x = r_base_x + $signed(POS_W'(scale_eff)) - $signed(POS_W'(1));
        end_y = r_base_y + $signed(POS_W'(scale_eff)) - $signed(POS_W'(1));
        lim_x = $signed(POS_W'(r_screen_width)) - $signed(POS_W'(1));
        lim_y = $signed(POS_W'(r_screen_height)) - $signed(POS_W'(1));
        lo_x  = (r_base_x < 0) ? '0 : r_base_x;
        lo_y  = (r_base_y < 0) ? '0 : r_base_y;
        hi_x  = (end_x < lim_x) ? end_x : lim_x;
        hi_y  = (end_y < lim_y) ? end_y : lim_y;
        empty = (lo_x > hi_x) || (lo_y > hi_y);
    end

    // Full product of the first visible row and the pitch; the address keeps its low bits.
    assign row_prod = (CRD_W+ssb_pkg::PITCH_W)'(r_y0) * (CRD_W+ssb_pkg::PITCH_W)'(r_row_pitch);

    assign cur_addr = r_row_base + ssb_pkg::ADDR_W'(r_x);
    assign last     = (r_x == r_x1) && (r_y == r_y1);

    assign o_sts.empty    = empty;
    assign o_sts.last     = last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_image_width   <= ssb_pkg::IW_W'(16);
            r_scale_factor  <= ssb_pkg::SCALE_W'(1);
            r_screen_width  <= ssb_pkg::SCR_W'(640);
            r_screen_height <= ssb_pkg::SCR_W'(480);
            r_row_pitch     <= ssb_pkg::PITCH_W'(640);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssb_pkg::CFG_ORIGIN_X:      r_origin_x      <= $signed(i_cfg_data);
                ssb_pkg::CFG_ORIGIN_Y:      r_origin_y      <= $signed(i_cfg_data);
                ssb_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[ssb_pkg::IW_W-1:0];
                ssb_pkg::CFG_SCALE_FACTOR:  r_scale_factor  <= i_cfg_data[ssb_pkg::SCALE_W-1:0];
                ssb_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[ssb_pkg::SCR_W-1:0];
                ssb_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[ssb_pkg::SCR_W-1:0];
                ssb_pkg::CFG_ROW_PITCH:     r_row_pitch     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if ((ssb_pkg::IW_W'(col_cur) + ssb_pkg::IW_W'(1)) >= width_eff) begin
                r_col <= '0;
                r_row <= row_cur + ssb_pkg::ROW_W'(1);
            end else begin
                r_col <= col_cur + ssb_pkg::COL_W'(1);
                r_row <= row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pixel  <= i_src_pixel;
            r_base_x <= base_x;
            r_base_y <= base_y;
        end
        if (i_cmd.clip) begin
            r_x0 <= lo_x[CRD_W-1:0];
            r_x1 <= hi_x[CRD_W-1:0];
            r_y0 <= lo_y[CRD_W-1:0];
            r_y1 <= hi_y[CRD_W-1:0];
        end
        if (i_cmd.setup) begin
            r_row_base <= row_prod[ssb_pkg::ADDR_W-1:0];
            r_x        <= r_x0;
            r_y        <= r_y0;
        end else if (i_cmd.emit) begin
            if (r_x == r_x1) begin
                r_x        <= r_x0;
                r_y        <= r_y + CRD_W'(1);
                r_row_base <= r_row_base + ssb_pkg::ADDR_W'(r_row_pitch);
            end else begin
                r_x <= r_x + CRD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_addr  <= cur_addr;
            r_out_pixel <= r_pixel;
            r_out_last  <= last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_word_address   = r_out_addr;
    assign o_pixel_value    = r_out_pixel;
    assign o_last_of_square = r_out_last;

endmodule

FILE: design/scaled_sprite_blitter_top.sv
// Nearest-neighbour scaling blitter. Each source pixel taken on the slave stream is drawn as a
// square of scale_factor by scale_factor screen pixels at the configured signed origin, and
// every position of that square that falls inside the screen comes out on the master stream
// as one framebuffer write (word address and pixel value), row by row and left to right, with
// tlast on the final write of the square. An item passes through set-up (take the pixel and
// form the square's corner, clip it, form the first row address) and then one write per
// visible position, and no new source pixel is taken until the item is done; a square that
// is wholly off screen ends after the clip and produces no write. The write rate is set by
// the single output register, which issues at most one write per cycle, and back-pressure
// on the master side stalls the walk over the square. Configuration registers should only
// be written while the block is idle.
module scaled_sprite_blitter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Source pixel stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ssb_pkg::PIX_W-1:0]           i_s_axis_tdata,   // [31:0] src_pixel
    input  logic                                i_s_axis_tuser,   // [0] image_start
    // Framebuffer write stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ssb_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,   // [22:0] word_address,
                                                                  // [54:23] pixel_value,
                                                                  // [55] zero
    output logic                                o_m_axis_tlast    // last_of_square
);

    ssb_pkg::t_dp_cmd           cmd;
    ssb_pkg::t_dp_sts           sts;
    logic [ssb_pkg::ADDR_W-1:0] word_address;
    logic [ssb_pkg::PIX_W-1:0]  pixel_value;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each item: accept, clip, address set-up, then one write per
    // free output slot until the last visible position of the square has gone out.
    ssb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, the source position counters, the clipped
    // bounds of the current square, the running row address and the output register.
    ssb_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_src_pixel      (i_s_axis_tdata),
        .i_image_start    (i_s_axis_tuser),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_word_address   (word_address),
        .o_pixel_value    (pixel_value),
        .o_last_of_square (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, pixel_value, word_address};

`ifndef SYNTHESIS
    // Once an item is taken the block is busy with it in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("source accepted twice in consecutive cycles");

    // A write is only loaded into the output register while the walk over a square runs.
    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_s_axis_tready && sts.out_free)
        else $error("write issued outside the square walk or into a full output register");

    // The final write of a square returns the block to idle.
    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && sts.last |=> o_s_axis_tready)
        else $error("block not idle after the last write of a square");
`endif

endmodule

FILE: tb/scaled_sprite_blitter_top_tb.sv
module scaled_sprite_blitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog ends the run after this many cycles in a row in which no channel moves an
    // item. The longest honest pause is a settling gap, a stall on either stream or the set-up
    // of a square, so this is many times that.
    localparam int STUCK_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int NUM_REGS = 7;

    // Register indexes in the order in which each phase writes them.
    localparam logic [ssb_pkg::CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
        ssb_pkg::CFG_ORIGIN_X, ssb_pkg::CFG_ORIGIN_Y, ssb_pkg::CFG_IMAGE_WIDTH,
        ssb_pkg::CFG_SCALE_FACTOR, ssb_pkg::CFG_SCREEN_WIDTH, ssb_pkg::CFG_SCREEN_HEIGHT,
        ssb_pkg::CFG_ROW_PITCH
    };

    typedef struct {
        logic [ssb_pkg::PIX_W-1:0] pixel;
        logic                      start;
    } t_src_pixel;

    typedef struct {
        logic [ssb_pkg::ADDR_W-1:0] addr;
        logic [ssb_pkg::PIX_W-1:0]  pixel;
        logic                       last;
    } t_fb_write;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ssb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ssb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [ssb_pkg::PIX_W-1:0]      i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [ssb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tlast;

    scaled_sprite_blitter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5ns i_clk = ~i_clk;

    // Source pixels waiting to be offered, and framebuffer writes that the accepted pixels
    // are owed, oldest first.
    t_src_pixel pixel_backlog [$];
    t_fb_write  fb_writes_due [$];

    int  items_sent = 0;
    int  items_accepted = 0;
    int  mismatch_count = 0;
    int  stuck_cycles = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  bursty = 1'b1;

    logic [ssb_pkg::CFG_DATA_W-1:0] reg_plan [NUM_REGS];

    // Our own copy of the register file, holding the raw written values at their widths
    // (sign-extended for the origins), and of the source position counters.
    int org_x = 0;
    int org_y = 0;
    int img_w = 16;
    int scale_f = 1;
    int scr_w = 640;
    int scr_h = 480;
    int pitch = 640;
    int src_col = 0;
    int src_row = 0;

    task automatic report_mismatch(string what, logic [ssb_pkg::PIX_W-1:0] got,
                                   logic [ssb_pkg::PIX_W-1:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void apply_reg(logic [ssb_pkg::CFG_IDX_W-1:0] idx,
                                      logic [ssb_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            ssb_pkg::CFG_ORIGIN_X:      org_x = int'($signed(d[ssb_pkg::ORG_W-1:0]));
            ssb_pkg::CFG_ORIGIN_Y:      org_y = int'($signed(d[ssb_pkg::ORG_W-1:0]));
            ssb_pkg::CFG_IMAGE_WIDTH:   img_w = int'(d[ssb_pkg::IW_W-1:0]);
            ssb_pkg::CFG_SCALE_FACTOR:  scale_f = int'(d[ssb_pkg::SCALE_W-1:0]);
            ssb_pkg::CFG_SCREEN_WIDTH:  scr_w = int'(d[ssb_pkg::SCR_W-1:0]);
            ssb_pkg::CFG_SCREEN_HEIGHT: scr_h = int'(d[ssb_pkg::SCR_W-1:0]);
            ssb_pkg::CFG_ROW_PITCH:     pitch = int'(d[ssb_pkg::PITCH_W-1:0]);
            default: ;
        endcase
    endfunction

    // Works out the framebuffer writes for one source pixel: the square is walked row by row
    // and left to right, clipped positions are skipped, and the final visible write carries
    // the last flag. Each write is held back until the next one is found so that the last
    // one can be marked before it is queued.
    function automatic void draw_square(logic [ssb_pkg::PIX_W-1:0] pix, logic start);
        int s, w, bx, by, fx, fy, sx, sy;
        t_fb_write wr;
        bit held;
        held = 1'b0;
        if (start) begin
            src_col = 0;
            src_row = 0;
        end
        s = (scale_f == 0) ? 1 :
            ((scale_f > ssb_pkg::MAX_SCALE) ? ssb_pkg::MAX_SCALE : scale_f);
        w = (img_w == 0) ? 1 :
            ((img_w > ssb_pkg::MAX_IMAGE_WIDTH) ? ssb_pkg::MAX_IMAGE_WIDTH : img_w);
        bx = org_x + src_col * s;
        by = org_y + src_row * s;
        for (sy = 0; sy < s; sy++) begin
            fy = by + sy;
            if (fy >= 0 && fy < scr_h) begin
                for (sx = 0; sx < s; sx++) begin
                    fx = bx + sx;
                    if (fx >= 0 && fx < scr_w) begin
                        if (held)
                            fb_writes_due.push_back(wr);
                        wr.addr = ssb_pkg::ADDR_W'(fy * pitch + fx);
                        wr.pixel = pix;
                        wr.last = 1'b0;
                        held = 1'b1;
                    end
                end
            end
        end
        if (held) begin
            wr.last = 1'b1;
            fb_writes_due.push_back(wr);
        end
        if (src_col + 1 >= w) begin
            src_col = 0;
            src_row = (src_row + 1) % (1 << ssb_pkg::ROW_W);
        end else begin
            src_col++;
        end
    endfunction

    function automatic void add_pixel(logic [ssb_pkg::PIX_W-1:0] pix, logic start);
        t_src_pixel item;
        item.pixel = pix;
        item.start = start;
        pixel_backlog.push_back(item);
        items_sent++;
    endfunction

    // Waits until every queued pixel has been taken and every write it caused has come out,
    // then runs out the settling gap, since a wholly clipped square keeps the block busy
    // without producing anything.
    task automatic settle();
        do @(posedge i_clk);
        while (items_accepted != items_sent || fb_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all seven registers back to back. Valid stays high from one write to the next
    // and is only lowered after the final handshake.
    task automatic configure(int ox, int oy, int w, int s, int sw, int sh, int p);
        int i;
        reg_plan[ssb_pkg::CFG_ORIGIN_X] = ssb_pkg::CFG_DATA_W'(ox);
        reg_plan[ssb_pkg::CFG_ORIGIN_Y] = ssb_pkg::CFG_DATA_W'(oy);
        reg_plan[ssb_pkg::CFG_IMAGE_WIDTH] = ssb_pkg::CFG_DATA_W'(w);
        reg_plan[ssb_pkg::CFG_SCALE_FACTOR] = ssb_pkg::CFG_DATA_W'(s);
        reg_plan[ssb_pkg::CFG_SCREEN_WIDTH] = ssb_pkg::CFG_DATA_W'(sw);
        reg_plan[ssb_pkg::CFG_SCREEN_HEIGHT] = ssb_pkg::CFG_DATA_W'(sh);
        reg_plan[ssb_pkg::CFG_ROW_PITCH] = ssb_pkg::CFG_DATA_W'(p);
        for (i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[i];
            i_cfg_data <= reg_plan[REG_ORDER[i]];
            do @(posedge i_clk);
            while (!o_cfg_ready);
            apply_reg(REG_ORDER[i], reg_plan[REG_ORDER[i]]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Source side: when the slot is free, either sit out an idle burst or offer the next
    // pending pixel. An accepted pixel is handed to the predictor straight away, with the
    // register copy as it stands, which is safe because registers only change while idle.
    always @(posedge i_clk) begin : source_driver
        t_src_pixel nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                draw_square(i_s_axis_tdata, i_s_axis_tuser);
                items_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    nxt = pixel_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= nxt.pixel;
                    i_s_axis_tuser <= nxt.start;
                    if (bursty && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 10);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Write side: every accepted write is checked field by field against the oldest write
    // that is due. Ready drops for random bursts while idling is enabled.
    always @(posedge i_clk) begin : write_monitor
        t_fb_write due;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (fb_writes_due.size() == 0) begin
                    report_mismatch("unexpected write",
                                    ssb_pkg::PIX_W'(o_m_axis_tdata[ssb_pkg::ADDR_W-1:0]), '0);
                end else begin
                    due = fb_writes_due.pop_front();
                    if (o_m_axis_tdata[ssb_pkg::ADDR_W-1:0] !== due.addr)
                        report_mismatch("word_address",
                                        ssb_pkg::PIX_W'(o_m_axis_tdata[ssb_pkg::ADDR_W-1:0]),
                                        ssb_pkg::PIX_W'(due.addr));
                    if (o_m_axis_tdata[ssb_pkg::ADDR_W+ssb_pkg::PIX_W-1:ssb_pkg::ADDR_W]
                        !== due.pixel)
                        report_mismatch("pixel_value",
                            o_m_axis_tdata[ssb_pkg::ADDR_W+ssb_pkg::PIX_W-1:ssb_pkg::ADDR_W],
                            due.pixel);
                    if (o_m_axis_tlast !== due.last)
                        report_mismatch("last_of_square", ssb_pkg::PIX_W'(o_m_axis_tlast),
                                        ssb_pkg::PIX_W'(due.last));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (bursty && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
        end
    end

    // Watchdog on dead cycles: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int ox, oy, w, s, sw, sh, p, n, k, random_items;
        random_items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 16 wide image, no scaling, 640 by 480 screen. Extremes of the
        // pixel value.
        add_pixel('0, 1'b1);
        add_pixel('1, 1'b0);
        add_pixel($urandom, 1'b0);
        settle();

        // Origin above and left of the screen, so the first squares lose their top row and
        // left columns; a three pixel wide image wraps onto its second row.
        configure(-2, -1, 3, 3, 640, 480, 640);
        add_pixel($urandom, 1'b1);
        repeat (3) add_pixel($urandom, 1'b0);
        settle();

        // Scale beyond the maximum behaves as the maximum; zero width puts every pixel on
        // a new row. The first square is cut at the right and bottom, the second is wholly
        // below the screen.
        configure(0, 2, 0, 15, 5, 6, 8191);
        add_pixel($urandom, 1'b1);
        repeat (2) add_pixel($urandom, 1'b0);
        settle();

        // Origin at the most negative row and the largest column: nothing visible. Zero scale
        // behaves as one, and a width above the maximum is capped.
        configure(4095, -4096, 2047, 0, 4095, 4095, 0);
        add_pixel($urandom, 1'b1);
        add_pixel($urandom, 1'b0);
        settle();

        // A zero screen width hides everything.
        configure(0, 0, 5, 2, 0, 100, 100);
        add_pixel($urandom, 1'b1);
        add_pixel($urandom, 1'b0);
        settle();

        // Zero pitch: the address is just the column.
        configure(10, 7, 2047, 2, 4095, 4095, 0);
        add_pixel($urandom, 1'b1);
        add_pixel($urandom, 1'b0);
        settle();

        // Largest pitch near the bottom of a large screen, so row times pitch runs past the
        // address width and must wrap.
        configure(4088, 2040, 1, 8, 4095, 2048, 8191);
        add_pixel(32'h5555_5555, 1'b1);
        add_pixel(32'hAAAA_AAAA, 1'b0);
        settle();

        // Shrinking the width mid-image: the column stands at five when the width drops to three,
        // so the next pixel still lands at column five and the one after it starts a new row.
        configure(0, 0, 8, 1, 640, 480, 640);
        add_pixel($urandom, 1'b1);
        repeat (4) add_pixel($urandom, 1'b0);
        settle();
        configure(0, 0, 3, 1, 640, 480, 640);
        repeat (2) add_pixel($urandom, 1'b0);
        settle();

        // Random phases. Most settings keep the image near the screen so that squares are
        // largely visible; now and then any register takes a value anywhere in its field.
        // Idling stops for the last stretch of the run.
        while (random_items < 325) begin
            if (random_items >= 280)
                bursty = 1'b0;
            ox = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191))
                                             : int'($urandom_range(0, 120)) - 20;
            oy = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191))
                                             : int'($urandom_range(0, 80)) - 20;
            w = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191))
                                            : int'($urandom_range(1, 12));
            s = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 8191))
                                            : int'($urandom_range(1, 4));
            sw = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191))
                                             : int'($urandom_range(1, 120));
            sh = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191))
                                             : int'($urandom_range(1, 60));
            p = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 8191))
                                            : int'($urandom_range(1, 200));
            configure(ox, oy, w, s, sw, sh, p);
            n = $urandom_range(5, 30);
            add_pixel($urandom, $urandom_range(0, 4) != 0);
            for (k = 1; k < n; k++)
                add_pixel($urandom, $urandom_range(0, 19) == 0);
            random_items += n;
            settle();
        end

        if (mismatch_count == 0 && fb_writes_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
